[hw/rtl/bip_pkg.sv]
// Package for the ballistic impact predictor: result kinds, datapath op codes,
// controller states, command/status structs and the saturation helper.
// No dependencies.
package bip_pkg;

    localparam int DefFracBits = 16;
    localparam int Dw          = 32;

    typedef enum logic [2:0] {
        KIND_TRAJ      = 3'd0,
        KIND_IMPACT    = 3'd1,
        KIND_NO_IMPACT = 3'd2,
        KIND_IDLE      = 3'd3,
        KIND_LOADED    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_ACCEL_X    = 3'd0,
        CFG_ACCEL_Y    = 3'd1,
        CFG_ACCEL_Z    = 3'd2,
        CFG_GROUND     = 3'd3,
        CFG_TIME_LIMIT = 3'd4,
        CFG_STEP_SIZE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE, OP_AX, OP_AY, OP_AZ, OP_VX, OP_VY, OP_VZ, OP_ADT, OP_LX, OP_LZ
    } t_op;

    typedef enum logic [1:0] {
        CM_NONE, CM_STEP, CM_STEP_END, CM_IMPACT
    } t_commit;

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_INTEG, S_DECIDE, S_DIV, S_LERP, S_SAMPLE, S_END
    } t_state;

    // Positions of the op sequence: integration ends at INTEG_END, lerp at LERP_END.
    localparam logic [3:0] INTEG_END = 4'd6;
    localparam logic [3:0] LERP_END  = 4'd9;

    typedef struct packed {
        logic    load;
        t_op     mul_op;
        t_op     acc_op;
        logic    div_start;
        logic    emit;
        t_kind   kind;
        logic    last;
        t_commit commit;
    } t_cmd;

    typedef struct packed {
        logic in_flight;
        logic out_free;
        logic impact;
        logic timeout;
        logic div_done;
    } t_stat;

    function automatic t_op op_at(input logic [3:0] k);
        t_op r;
        unique case (k)
            4'd0:    r = OP_AX;
            4'd1:    r = OP_AY;
            4'd2:    r = OP_AZ;
            4'd3:    r = OP_VX;
            4'd4:    r = OP_VY;
            4'd5:    r = OP_VZ;
            4'd6:    r = OP_ADT;
            4'd7:    r = OP_LX;
            4'd8:    r = OP_LZ;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction

    // Saturates a wide signed value to 32 signed bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if ((&v[65:31]) || !(|v[65:31])) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

[hw/rtl/ballistic_impact_predictor_core.sv]
// A load or an idle step registers its beat from S_FIRST once the output register is free.
// A flight step walks the integration ops, then emits from S_SAMPLE (and S_END when it ends);
// one ending in impact first runs the bit-serial impact divider (one quotient bit a cycle).
// One item is worked at a time; the next is taken once the last beat is registered.
// Reset (i_rst_n low, synchronous) restores the default registers and an idle,
// zeroed flight state. Depends on bip_pkg, bip_ctrl, bip_datapath.
module ballistic_impact_predictor_core #(
    parameter int FRAC_BITS = bip_pkg::DefFracBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,  // start_px, start_py, start_pz, start_vx, start_vy, start_vz
    input  logic         i_s_tuser,  // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [223:0] o_m_tdata,  // sample_time, out_px, out_py, out_pz, out_vx, out_vy, out_vz
    output logic [2:0]   o_m_tuser,  // sample_kind
    output logic         o_m_tlast   // last_of_run
);
    import bip_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bip_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

[hw/rtl/bip_div.sv]
// Restoring divider for the impact fraction: (num << FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits; one quotient bit a cycle.
// Depends on bip_pkg.
module bip_div #(
    parameter int FRAC_BITS = bip_pkg::DefFracBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_alpha
);
    import bip_pkg::*;

    localparam int Nw = 33 + FRAC_BITS;
    localparam int Cw = $clog2(Nw + 1);

    logic [Nw-1:0] r_dq;
    logic [32:0]   r_rem;
    logic [32:0]   r_den;
    logic          r_neg;
    logic          r_zero;
    logic          r_busy;
    logic [Cw-1:0] r_cnt;
    logic          r_done;

    logic [33:0]   trial;
    logic [33:0]   diff;
    logic [32:0]   num_mag;
    logic [32:0]   den_mag;

    assign num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
    assign den_mag = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign trial   = {r_rem, r_dq[Nw-1]};
    assign diff    = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == Cw'(Nw - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq   <= {num_mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= den_mag;
            r_neg  <= i_num[32] ^ i_den[32];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            if (!diff[33]) begin
                r_rem <= diff[32:0];
                r_dq  <= {r_dq[Nw-2:0], 1'b1};
            end else begin
                r_rem <= trial[32:0];
                r_dq  <= {r_dq[Nw-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_alpha = '0;
        end else if (r_neg) begin
            if ((|r_dq[Nw-1:32]) || (r_dq[31] && (|r_dq[30:0]))) begin
                o_alpha = 32'sh8000_0000;
            end else begin
                o_alpha = -$signed(r_dq[31:0]);
            end
        end else if (|r_dq[Nw-1:31]) begin
            o_alpha = 32'sh7fff_ffff;
        end else begin
            o_alpha = $signed(r_dq[31:0]);
        end
    end

    assign o_done = r_done;

endmodule

[hw/rtl/bip_datapath.sv]
// Datapath: configuration and flight state registers, the shared multiplier
// with its saturating accumulate, the impact divider and the output register.
// Depends on bip_pkg and bip_div.
module bip_datapath #(
    parameter int FRAC_BITS = bip_pkg::DefFracBits
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  logic [191:0]          i_s_tdata,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [223:0]          o_m_tdata,
    output logic [2:0]            o_m_tuser,
    output logic                  o_m_tlast,
    input  bip_pkg::t_cmd         i_cmd,
    output bip_pkg::t_stat        o_stat
);
    import bip_pkg::*;

    localparam longint One        = 64'sd1 <<< FRAC_BITS;
    localparam longint GravRst    = -((981 * One + 50) / 100);
    localparam longint LimitRst   = 10 * One;
    localparam longint StepRst    = (One + 50) / 100;

    logic signed [31:0] r_ax, r_ay, r_az, r_ground;
    logic [30:0]        r_limit, r_dt;

    logic signed [31:0] r_px, r_py, r_pz, r_vx, r_vy, r_vz, r_t;
    logic               r_fly;
    logic signed [31:0] r_nvx, r_nvy, r_nvz, r_nx, r_ny, r_nz, r_it, r_ix, r_iz;

    logic signed [65:0] r_prod;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_sh;
    logic signed [31:0] prod_sat;
    logic signed [31:0] acc_base;
    logic signed [31:0] acc_qadd;
    logic signed [31:0] acc_lerp;

    logic               r_ov;
    logic [223:0]       r_odata;
    logic [2:0]         r_okind;
    logic               r_olast;
    logic               out_free;

    logic signed [32:0] next_t;
    logic               div_done;
    logic signed [31:0] alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax     <= '0;
            r_ay     <= 32'(GravRst);
            r_az     <= '0;
            r_ground <= '0;
            r_limit  <= 31'(LimitRst);
            r_dt     <= 31'(StepRst);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_X:    r_ax     <= i_cfg_data;
                CFG_ACCEL_Y:    r_ay     <= i_cfg_data;
                CFG_ACCEL_Z:    r_az     <= i_cfg_data;
                CFG_GROUND:     r_ground <= i_cfg_data;
                CFG_TIME_LIMIT: r_limit  <= i_cfg_data[30:0];
                CFG_STEP_SIZE:  r_dt     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Multiplier operand selection; the product is registered before use.
    always_comb begin
        mul_a = '0;
        mul_b = {2'b00, r_dt};
        case (i_cmd.mul_op)
            OP_AX:  mul_a = 33'(r_ax);
            OP_AY:  mul_a = 33'(r_ay);
            OP_AZ:  mul_a = 33'(r_az);
            OP_VX:  mul_a = 33'(r_nvx);
            OP_VY:  mul_a = 33'(r_nvy);
            OP_VZ:  mul_a = 33'(r_nvz);
            OP_ADT: mul_a = 33'(alpha);
            OP_LX: begin
                mul_a = 33'(r_nx) - 33'(r_px);
                mul_b = 33'(alpha);
            end
            OP_LZ: begin
                mul_a = 33'(r_nz) - 33'(r_pz);
                mul_b = 33'(alpha);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        case (i_cmd.acc_op)
            OP_AX:         acc_base = r_vx;
            OP_AY:         acc_base = r_vy;
            OP_AZ:         acc_base = r_vz;
            OP_VX, OP_LX:  acc_base = r_px;
            OP_VY:         acc_base = r_py;
            OP_VZ, OP_LZ:  acc_base = r_pz;
            OP_ADT:        acc_base = r_t;
            default:       acc_base = '0;
        endcase
    end

    // Arithmetic shift of the signed product floors toward minus infinity.
    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign prod_sat = sat32(prod_sh);
    assign acc_qadd = sat32(66'(acc_base) + 66'(prod_sat));
    assign acc_lerp = sat32(66'(acc_base) + prod_sh);

    assign next_t   = 33'(r_t) + {2'b00, r_dt};
    assign out_free = !r_ov || i_m_tready;

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            OP_AX:  r_nvx <= acc_qadd;
            OP_AY:  r_nvy <= acc_qadd;
            OP_AZ:  r_nvz <= acc_qadd;
            OP_VX:  r_nx  <= acc_qadd;
            OP_VY:  r_ny  <= acc_qadd;
            OP_VZ:  r_nz  <= acc_qadd;
            OP_ADT: r_it  <= acc_qadd;
            OP_LX:  r_ix  <= acc_lerp;
            OP_LZ:  r_iz  <= acc_lerp;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_pz  <= '0;
            r_vx  <= '0;
            r_vy  <= '0;
            r_vz  <= '0;
            r_t   <= '0;
            r_fly <= 1'b0;
        end else if (i_cmd.load) begin
            r_px  <= i_s_tdata[31:0];
            r_py  <= i_s_tdata[63:32];
            r_pz  <= i_s_tdata[95:64];
            r_vx  <= i_s_tdata[127:96];
            r_vy  <= i_s_tdata[159:128];
            r_vz  <= i_s_tdata[191:160];
            r_t   <= '0;
            r_fly <= 1'b1;
        end else begin
            case (i_cmd.commit)
                CM_STEP, CM_STEP_END: begin
                    r_px <= r_nx;
                    r_py <= r_ny;
                    r_pz <= r_nz;
                    r_vx <= r_nvx;
                    r_vy <= r_nvy;
                    r_vz <= r_nvz;
                    r_t  <= sat32(66'(next_t));
                    if (i_cmd.commit == CM_STEP_END) begin
                        r_fly <= 1'b0;
                    end
                end
                CM_IMPACT: begin
                    r_px  <= r_ix;
                    r_py  <= r_ground;
                    r_pz  <= r_iz;
                    r_t   <= r_it;
                    r_fly <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    bip_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (33'(r_ground) - 33'(r_py)),
        .i_den   (33'(r_ny) - 33'(r_py)),
        .o_done  (div_done),
        .o_alpha (alpha)
    );

    // The output register always shows the stored state at the time of the emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= {r_vz, r_vy, r_vx, r_pz, r_py, r_px, r_t};
            r_okind <= i_cmd.kind;
            r_olast <= i_cmd.last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    assign o_stat.in_flight = r_fly;
    assign o_stat.out_free  = out_free;
    assign o_stat.impact    = (r_ny <= r_ground);
    assign o_stat.timeout   = (next_t > $signed({2'b00, r_limit}));
    assign o_stat.div_done  = div_done;

endmodule

[hw/rtl/bip_ctrl.sv]
// Controller: accepts items, walks the multiply/accumulate sequence, waits on
// the divider and orders the result beats. Depends on bip_pkg.
module bip_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tuser,
    output logic            o_s_tready,
    input  bip_pkg::t_stat  i_stat,
    output bip_pkg::t_cmd   o_cmd
);
    import bip_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_k, n_k;
    t_kind      r_kind, n_kind;
    logic       accept;

    assign accept = (r_state == S_IDLE) && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_kind  <= KIND_TRAJ;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_kind  = r_kind;
        unique case (r_state)
            S_IDLE: begin
                n_k = '0;
                if (accept) begin
                    if (!i_s_tuser) begin
                        n_kind  = KIND_LOADED;
                        n_state = S_FIRST;
                    end else if (!i_stat.in_flight) begin
                        n_kind  = KIND_IDLE;
                        n_state = S_FIRST;
                    end else begin
                        n_state = S_INTEG;
                    end
                end
            end
            S_FIRST: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_INTEG: begin
                if (r_k == INTEG_END) begin
                    n_state = S_DECIDE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DECIDE: begin
                if (i_stat.impact) begin
                    n_kind  = KIND_IMPACT;
                    n_state = S_DIV;
                end else begin
                    n_kind  = i_stat.timeout ? KIND_NO_IMPACT : KIND_TRAJ;
                    n_state = S_SAMPLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                if (r_k == LERP_END) begin
                    n_state = S_SAMPLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SAMPLE: begin
                if (i_stat.out_free) begin
                    n_state = (r_kind == KIND_TRAJ) ? S_IDLE : S_END;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd           = '0;
        o_cmd.mul_op    = OP_NONE;
        o_cmd.acc_op    = OP_NONE;
        o_cmd.kind      = KIND_TRAJ;
        o_cmd.commit    = CM_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = accept && !i_s_tuser;
            end
            S_FIRST: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = r_kind;
                o_cmd.last = 1'b1;
            end
            S_INTEG: begin
                // Multiply for op k and accumulate for op k-1 overlap.
                o_cmd.mul_op = (r_k < INTEG_END) ? op_at(r_k) : OP_NONE;
                o_cmd.acc_op = (r_k != '0) ? op_at(r_k - 1'b1) : OP_NONE;
            end
            S_DECIDE: begin
                o_cmd.div_start = i_stat.impact;
            end
            S_DIV: ;
            S_LERP: begin
                o_cmd.mul_op = (r_k < LERP_END) ? op_at(r_k) : OP_NONE;
                o_cmd.acc_op = (r_k != INTEG_END) ? op_at(r_k - 1'b1) : OP_NONE;
            end
            S_SAMPLE: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = KIND_TRAJ;
                o_cmd.last = (r_kind == KIND_TRAJ);
                if (i_stat.out_free) begin
                    unique case (r_kind)
                        KIND_IMPACT:    o_cmd.commit = CM_IMPACT;
                        KIND_NO_IMPACT: o_cmd.commit = CM_STEP_END;
                        default:        o_cmd.commit = CM_STEP;
                    endcase
                end
            end
            S_END: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = r_kind;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/bip_checker.sv]
// Port-level checks for the predictor core, bound to the top level.
// Depends on bip_pkg.
module bip_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [223:0] o_m_tdata,
    input logic [2:0]   o_m_tuser,
    input logic         o_m_tlast
);
    import bip_pkg::*;

    // A stalled beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == KIND_TRAJ || o_m_tuser == KIND_IMPACT
            || o_m_tuser == KIND_NO_IMPACT || o_m_tuser == KIND_IDLE
            || o_m_tuser == KIND_LOADED)
        else $error("sample kind out of range");

    // Every kind other than a trajectory sample closes its run.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != KIND_TRAJ |-> o_m_tlast)
        else $error("closing kind without tlast");

    a_load_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_LOADED |-> o_m_tdata[31:0] == 32'd0)
        else $error("loaded sample with non-zero time");

endmodule

bind ballistic_impact_predictor_core bip_checker u_bip_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

[test/ballistic_impact_predictor_core_tb.sv]
// Self-checking bench for ballistic_impact_predictor_core: directed flights, then random
// flights under several register settings, checked beat by beat. Depends on bip_pkg.
module ballistic_impact_predictor_core_tb;
    import bip_pkg::*;

    typedef struct {
        logic        step;
        logic [31:0] f[6];
    } req_t;

    typedef struct {
        logic [31:0] w[7];
        t_kind       kind;
        logic        last;
    } sample_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [223:0] o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         o_m_tlast;

    ballistic_impact_predictor_core u_dut (.*);

    // Predictor copy of the registers and the flight state.
    logic signed [31:0] acc[3];
    logic signed [31:0] ground;
    logic [30:0]        t_limit;
    logic [30:0]        dt_q;
    logic signed [31:0] pos[3];
    logic signed [31:0] vel[3];
    logic signed [31:0] t_now;
    logic               flying;

    req_t    pending[$];
    req_t    cur;
    sample_t samples_due[$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_cycles   = 0;
    int      hold_req      = 0;
    int      errors        = 0;
    int      n_in          = 0;
    int      n_out         = 0;
    int      n_impact      = 0;
    int      n_timeout     = 0;
    int      quiet         = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7fff_ffff;
        if (v < -96'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Exact product, floor shift by the fraction width, then saturation.
    function automatic logic signed [31:0] fx_mul(input logic signed [95:0] a,
                                                  input logic signed [95:0] b);
        logic signed [95:0] p;
        p = a * b;
        return clamp32(p >>> DefFracBits);
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [95:0] a,
                                                  input logic signed [95:0] b);
        return clamp32(a + b);
    endfunction

    function automatic logic signed [31:0] fx_lerp(input logic signed [95:0] a,
                                                   input logic signed [95:0] b,
                                                   input logic signed [95:0] alpha);
        logic signed [95:0] p;
        p = (b - a) * alpha;
        return clamp32(a + (p >>> DefFracBits));
    endfunction

    function automatic void push_sample(input t_kind kind, input logic last);
        sample_t s;
        s.w[0] = t_now;
        for (int i = 0; i < 3; i++) begin
            s.w[1 + i] = pos[i];
            s.w[4 + i] = vel[i];
        end
        s.kind = kind;
        s.last = last;
        samples_due.push_back(s);
    endfunction

    function automatic void predict_flight(input req_t r);
        logic signed [95:0] dt, num, dy, next_t;
        logic signed [31:0] p0[3], v0[3], np[3], alpha;
        sample_t            tail;
        dt = $signed({65'd0, dt_q});
        if (!r.step) begin
            for (int i = 0; i < 3; i++) begin
                pos[i] = r.f[i];
                vel[i] = r.f[3 + i];
            end
            t_now  = 0;
            flying = 1'b1;
            push_sample(KIND_LOADED, 1'b1);
            return;
        end
        if (!flying) begin
            push_sample(KIND_IDLE, 1'b1);
            return;
        end
        push_sample(KIND_TRAJ, 1'b0);
        for (int i = 0; i < 3; i++) begin
            p0[i]  = pos[i];
            v0[i]  = vel[i];
            vel[i] = fx_add(vel[i], fx_mul(acc[i], dt));
            np[i]  = fx_add(p0[i], fx_mul(vel[i], dt));
        end
        if (np[1] <= ground) begin
            dy    = np[1] - p0[1];
            alpha = 0;
            if (dy != 0) begin
                num   = (ground - p0[1]) * 96'sd65536;
                alpha = clamp32(num / dy);
            end
            t_now  = fx_add(t_now, fx_mul(alpha, dt));
            pos[0] = fx_lerp(p0[0], np[0], alpha);
            pos[1] = ground;
            pos[2] = fx_lerp(p0[2], np[2], alpha);
            vel    = v0;
            flying = 1'b0;
            push_sample(KIND_IMPACT, 1'b1);
            return;
        end
        pos    = np;
        next_t = t_now + dt;
        t_now  = clamp32(next_t);
        if (next_t > $signed({65'd0, t_limit})) begin
            flying = 1'b0;
            push_sample(KIND_NO_IMPACT, 1'b1);
            return;
        end
        // A plain trajectory step closes its run with its only beat.
        tail      = samples_due.pop_back();
        tail.last = 1'b1;
        samples_due.push_back(tail);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch at beat %0d: %s got %h expected %h", n_out, what, got, want);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ACCEL_X:    acc[0]  = data;
            CFG_ACCEL_Y:    acc[1]  = data;
            CFG_ACCEL_Z:    acc[2]  = data;
            CFG_GROUND:     ground  = data;
            CFG_TIME_LIMIT: t_limit = data[30:0];
            CFG_STEP_SIZE:  dt_q    = data[30:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_req(input logic step, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz);
        req_t r;
        r.step = step;
        r.f = '{px, py, pz, vx, vy, vz};
        pending.push_back(r);
    endtask

    // Mostly whole flights (a load, then a run of steps) with some noise in between.
    task automatic add_flights(input int n);
        int k, steps;
        k = 0;
        while (k < n) begin
            if ($urandom_range(99) < 12) begin
                add_req(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
                k++;
            end else begin
                add_req(1'b0, $urandom, ground + $urandom_range(0, 20 << 16) - (1 << 16),
                        $urandom, $urandom, $signed($urandom_range(0, 32 << 16)) - (8 << 16),
                        $urandom);
                steps = $urandom_range(1, 40);
                repeat (steps) add_req(1'b1, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom);
                k += steps + 1;
            end
        end
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (pending.size() != 0 || i_s_tvalid || samples_due.size() != 0);
        // Allow for any step still in the impact divider.
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_flight(cur);
                n_in++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur = pending.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= cur.step;
                    i_s_tdata  <= {cur.f[5], cur.f[4], cur.f[3], cur.f[2], cur.f[1], cur.f[0]};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_cycles = hold_req;
            hold_req    = 0;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_out++;
            if (samples_due.size() == 0) begin
                report_mismatch("beat with nothing due, kind", 32'(o_m_tuser), '0);
            end else begin
                want = samples_due.pop_front();
                for (int i = 0; i < 7; i++)
                    if (o_m_tdata[32*i +: 32] !== want.w[i])
                        report_mismatch($sformatf("word %0d", i), o_m_tdata[32*i +: 32],
                                        want.w[i]);
                if (o_m_tuser !== want.kind)
                    report_mismatch("kind", 32'(o_m_tuser), 32'(want.kind));
                if (o_m_tlast !== want.last)
                    report_mismatch("last", 32'(o_m_tlast), 32'(want.last));
                if (want.kind == KIND_IMPACT) n_impact++;
                if (want.kind == KIND_NO_IMPACT) n_timeout++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == 5000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        acc     = '{0, -642908, 0};
        ground  = 0;
        t_limit = 31'd655360;
        dt_q    = 31'd655;
        pos     = '{0, 0, 0};
        vel     = '{0, 0, 0};
        t_now   = 0;
        flying  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset registers.
        send_idle_pct = 20;
        recv_idle_pct = 85;
        add_req(1'b1, 0, 0, 0, 0, 0, 0);
        add_req(1'b0, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1);
        add_req(1'b1, '1, '1, '1, '1, '1, '1);
        add_req(1'b1, 0, 0, 0, 0, 0, 0);
        add_req(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
        add_req(1'b1, 0, 0, 0, 0, 0, 0);
        add_req(1'b0, 1 << 16, 10 << 16, 0, 2 << 16, 5 << 16, -(1 << 16));
        repeat (3) add_req(1'b1, 0, 0, 0, 0, 0, 0);
        add_req(1'b0, 0, 0, 0, 0, 0, 0);
        add_req(1'b1, 0, 0, 0, 0, 0, 0);
        drain();

        // Flat height at ground and a short time limit for the no-impact end.
        write_reg(CFG_ACCEL_Y, 0);
        write_reg(CFG_TIME_LIMIT, 3 * 655);
        add_req(1'b0, 0, 0, 0, 0, 0, 0);
        add_req(1'b1, 0, 0, 0, 0, 0, 0);
        add_req(1'b0, 0, 100 << 16, 0, 1 << 16, 1 << 16, 0);
        repeat (5) add_req(1'b1, 0, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 85 : 0;
            recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 20 : 0;
            case (ph)
                1: begin
                    write_reg(CFG_ACCEL_X, 32'h7fff_ffff);
                    write_reg(CFG_ACCEL_Y, 32'h8000_0000);
                    write_reg(CFG_ACCEL_Z, 32'h8000_0000);
                    write_reg(CFG_GROUND, 32'h7fff_ffff);
                    write_reg(CFG_TIME_LIMIT, 32'hffff_ffff);
                    write_reg(CFG_STEP_SIZE, 32'hffff_ffff);
                end
                3: begin
                    write_reg(CFG_ACCEL_Y, 32'h7fff_ffff);
                    write_reg(CFG_GROUND, 32'h8000_0000);
                    write_reg(CFG_TIME_LIMIT, 32'h8000_0001);
                    write_reg(CFG_STEP_SIZE, 32'h8000_0000);
                end
                5: begin
                    write_reg(CFG_TIME_LIMIT, 0);
                    write_reg(CFG_STEP_SIZE, 1);
                end
                default: begin
                    write_reg(CFG_ACCEL_X, $signed($urandom_range(0, 40 << 16)) - (20 << 16));
                    write_reg(CFG_ACCEL_Y, -$signed($urandom_range(0, 30 << 16)));
                    write_reg(CFG_ACCEL_Z, $signed($urandom_range(0, 40 << 16)) - (20 << 16));
                    write_reg(CFG_GROUND, $signed($urandom_range(0, 200 << 16)) - (100 << 16));
                    write_reg(CFG_TIME_LIMIT, $urandom_range(1, 8 << 16));
                    write_reg(CFG_STEP_SIZE, $urandom_range(655, 20000));
                end
            endcase
            add_flights(160);
            // Long receiver stall while items keep coming, so the input backs up.
            if (ph == 4) hold_req = 400;
            drain();
        end

        $display("%0d items in, %0d result beats checked (%0d impacts, %0d time-outs)",
                 n_in, n_out, n_impact, n_timeout);
        $display("register settings: reset, extremes, zero limit, random; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/bip_pkg.sv
hw/rtl/bip_div.sv
hw/rtl/bip_datapath.sv
hw/rtl/bip_ctrl.sv
hw/rtl/ballistic_impact_predictor_core.sv
hw/rtl/bip_checker.sv
test/ballistic_impact_predictor_core_tb.sv
